// ----- design/bracket_balance_checker_top_macros.svh -----
// Assertion macros shared by the bracket checker modules.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef BRACKET_BALANCE_CHECKER_TOP_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BBC_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("bbc assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define BBC_ASSERT_NEXT(lbl, trig, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (expr)) \
        else $error("bbc assertion failed");

`endif

// ----- design/bbc_pkg.sv -----
// Shared constants, types and bracket decode functions for the bracket checker.
// No dependencies.
package bbc_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int MAX_LEN     = 65536;
    localparam int POS_W       = 17;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLOSE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OPEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd3;

    localparam logic [1:0] KIND_PAREN = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY = 2'd2;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    // One stack entry: bracket kind and its 1-based position.
    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] pos;
    } entry_t;

    // Stack operation requested by the control logic.
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   clear;
        entry_t wr;
    } stack_op_t;

    // Stack state seen by the control logic.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        entry_t           tos;
        entry_t           below;
    } stack_stat_t;

    // Decoded bracket byte.
    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } bracket_t;

    function automatic bracket_t open_kind(input logic [7:0] c);
        bracket_t b;
        b.hit  = 1'b1;
        b.kind = KIND_PAREN;
        case (c)
            CH_LPAREN:  b.kind = KIND_PAREN;
            CH_LSQUARE: b.kind = KIND_SQUARE;
            CH_LCURLY:  b.kind = KIND_CURLY;
            default:    b.hit = 1'b0;
        endcase
        return b;
    endfunction

    function automatic bracket_t close_kind(input logic [7:0] c);
        bracket_t b;
        b.hit  = 1'b1;
        b.kind = KIND_PAREN;
        case (c)
            CH_RPAREN:  b.kind = KIND_PAREN;
            CH_RSQUARE: b.kind = KIND_SQUARE;
            CH_RCURLY:  b.kind = KIND_CURLY;
            default:    b.hit = 1'b0;
        endcase
        return b;
    endfunction

endpackage

// ----- design/bbc_stack.sv -----
// Bracket stack: top entry in registers, deeper entries in a synchronous RAM.
// Depends on bbc_pkg and bracket_balance_checker_top_macros.svh.
`include "bracket_balance_checker_top_macros.svh"

module bbc_stack (
    input  logic                aclk,
    input  logic                aresetn,
    input  bbc_pkg::stack_op_t  op,
    output bbc_pkg::stack_stat_t stat
);

    logic [bbc_pkg::CNT_W-1:0]  count_reg;
    logic [bbc_pkg::CNT_W-1:0]  count_next;
    bbc_pkg::entry_t            tos_reg;
    bbc_pkg::entry_t            tos_next;
    bbc_pkg::entry_t            fwd_reg;
    logic                       fwd_valid_reg;
    bbc_pkg::entry_t            rd_data_reg;
    bbc_pkg::entry_t            below;
    logic [bbc_pkg::CNT_W-1:0]  wr_diff;
    logic [bbc_pkg::CNT_W-1:0]  rd_diff;
    logic [bbc_pkg::ADDR_W-1:0] wr_addr;
    logic [bbc_pkg::ADDR_W-1:0] rd_addr;

    bbc_pkg::entry_t mem [bbc_pkg::STACK_DEPTH];

    // Entry under the top: forwarded after a push, else from the RAM
    assign below = fwd_valid_reg ? fwd_reg : rd_data_reg;

    // Next depth and top entry
    always_comb begin
        count_next = count_reg;
        tos_next   = tos_reg;
        if (op.push) begin
            count_next = count_reg + 1'b1;
            tos_next   = op.wr;
        end else if (op.pop) begin
            count_next = count_reg - 1'b1;
            tos_next   = below;
        end
        if (op.clear) begin
            count_next = '0;
        end
    end

    // Spill the old top at count-1, prefetch the entry under the new top
    assign wr_diff = count_reg - 1'b1;
    assign rd_diff = count_next - 2'd2;
    assign wr_addr = wr_diff[bbc_pkg::ADDR_W-1:0];
    assign rd_addr = rd_diff[bbc_pkg::ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (op.push) begin
            mem[wr_addr] <= tos_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Hold the spilled entry when the prefetch hits the entry being written
    always_ff @(posedge aclk) begin
        fwd_reg <= tos_reg;
        tos_reg <= tos_next;
        if (!aresetn) begin
            count_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            fwd_valid_reg <= op.push;
        end
    end

    assign stat.count = count_reg;
    assign stat.tos   = tos_reg;
    assign stat.below = below;

    `BBC_ASSERT_ALWAYS(a_no_push_full, !op.push || (count_reg < bbc_pkg::STACK_DEPTH))
    `BBC_ASSERT_ALWAYS(a_no_pop_empty, !op.pop || (count_reg != '0))
    `BBC_ASSERT_NEXT(a_push_top, op.push, tos_reg == $past(op.wr))
    `BBC_ASSERT_NEXT(a_pop_depth, op.pop && !op.clear, count_reg == $past(count_reg) - 1'b1)

endmodule

// ----- design/bracket_balance_checker_top.sv -----
// Bracket balance checker: one byte per cycle while s_axis_tready is high, one result
// per string. The result of a last item is registered in the output register, or in
// the skid stage while that register is stalled. The RAM prefetch of the entry under
// the top keeps one item per cycle; tready is low only while the skid stage is full.
// Reset (aresetn low, synchronous) clears depth, counters, error state and output valid flags.
// The stack RAM needs no clearing pass; only written entries are read.
`include "bracket_balance_checker_top_macros.svh"

module bracket_balance_checker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] no_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [1:0] status, [18:2] position, [23:19] zero
);

    localparam int RES_W = bbc_pkg::STATUS_W + bbc_pkg::POS_W;

    logic                          accept;
    logic                          take;
    logic                          len_ovf;
    logic [bbc_pkg::POS_W-1:0]     pos;
    bbc_pkg::bracket_t             ob;
    bbc_pkg::bracket_t             cb;
    bbc_pkg::stack_op_t            op;
    bbc_pkg::stack_stat_t          stat;

    logic [bbc_pkg::POS_W-1:0]     char_count_reg;
    logic [bbc_pkg::POS_W-1:0]     char_count_next;
    logic                          err_flag_reg;
    logic                          err_flag_next;
    logic [bbc_pkg::STATUS_W-1:0]  err_code_reg;
    logic [bbc_pkg::STATUS_W-1:0]  err_code_next;
    logic [bbc_pkg::POS_W-1:0]     err_pos_reg;
    logic [bbc_pkg::POS_W-1:0]     err_pos_next;

    logic [bbc_pkg::CNT_W-1:0]     count_post;
    logic [bbc_pkg::POS_W-1:0]     tos_pos_post;
    logic [RES_W-1:0]              result;
    logic                          emit;

    logic                          out_valid_reg;
    logic [RES_W-1:0]              out_data_reg;
    logic                          skid_valid_reg;
    logic [RES_W-1:0]              skid_data_reg;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = accept && !s_axis_tuser && !err_flag_reg;
    assign len_ovf       = char_count_reg >= bbc_pkg::POS_W'(bbc_pkg::MAX_LEN);
    assign pos           = char_count_reg + 1'b1;
    assign ob            = bbc_pkg::open_kind(s_axis_tdata);
    assign cb            = bbc_pkg::close_kind(s_axis_tdata);

    // Decode the byte into a stack operation or a latched error
    always_comb begin
        op.push         = 1'b0;
        op.pop          = 1'b0;
        op.clear        = accept && s_axis_tlast;
        op.wr.kind      = ob.kind;
        op.wr.pos       = pos;
        char_count_next = char_count_reg;
        err_flag_next   = err_flag_reg;
        err_code_next   = err_code_reg;
        err_pos_next    = err_pos_reg;
        if (take) begin
            if (len_ovf) begin
                err_flag_next = 1'b1;
                err_code_next = bbc_pkg::ST_OVF;
                err_pos_next  = '0;
            end else begin
                char_count_next = pos;
                if (ob.hit) begin
                    if (stat.count >= bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH)) begin
                        err_flag_next = 1'b1;
                        err_code_next = bbc_pkg::ST_OVF;
                        err_pos_next  = pos;
                    end else begin
                        op.push = 1'b1;
                    end
                end else if (cb.hit) begin
                    if (stat.count == '0 || stat.tos.kind != cb.kind) begin
                        err_flag_next = 1'b1;
                        err_code_next = bbc_pkg::ST_CLOSE;
                        err_pos_next  = pos;
                    end else begin
                        op.pop = 1'b1;
                    end
                end
            end
        end
    end

    // Form the result from the state after this byte
    always_comb begin
        count_post   = stat.count;
        tos_pos_post = stat.tos.pos;
        if (op.push) begin
            count_post   = stat.count + 1'b1;
            tos_pos_post = pos;
        end else if (op.pop) begin
            count_post   = stat.count - 1'b1;
            tos_pos_post = stat.below.pos;
        end
        if (err_flag_next) begin
            result = {err_pos_next, err_code_next};
        end else if (count_post == '0) begin
            result = {{bbc_pkg::POS_W{1'b0}}, bbc_pkg::ST_OK};
        end else begin
            result = {tos_pos_post, bbc_pkg::ST_OPEN};
        end
    end

    assign emit = accept && s_axis_tlast;

    bbc_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .stat    (stat)
    );

    // Advance string state; clear it at the end of each string
    always_ff @(posedge aclk) begin
        if (!aresetn || emit) begin
            char_count_reg <= '0;
            err_flag_reg   <= 1'b0;
            err_code_reg   <= bbc_pkg::ST_OK;
            err_pos_reg    <= '0;
        end else begin
            char_count_reg <= char_count_next;
            err_flag_reg   <= err_flag_next;
            err_code_reg   <= err_code_next;
            err_pos_reg    <= err_pos_next;
        end
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_axis_tready) begin
                out_valid_reg  <= skid_valid_reg || emit;
                skid_valid_reg <= 1'b0;
                out_data_reg   <= skid_valid_reg ? skid_data_reg : result;
            end else if (emit) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                    skid_data_reg  <= result;
                end else begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= result;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(24 - RES_W){1'b0}}, out_data_reg};

    `BBC_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_reg || out_valid_reg)
    `BBC_ASSERT_ALWAYS(a_one_stack_op, !(op.push && op.pop))
    `BBC_ASSERT_NEXT(a_emit_shows, emit, m_axis_tvalid)

endmodule
